FILE: rtl/core/lbs_pkg.sv
package lbs_pkg;

  // frame store size in pixels
  localparam int MAX_SRC_WIDTH  = 64;
  localparam int MAX_SRC_HEIGHT = 64;

  // shared divider geometry
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 14;
  localparam int DIV_CW = 5;

  // register indexes
  localparam logic [2:0] REG_SRC_WIDTH      = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_CANVAS_WIDTH   = 3'd2;
  localparam logic [2:0] REG_CANVAS_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_STRAIGHT_ALPHA = 3'd4;

  // request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DIM = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [5:0]  src_col;
    logic [5:0]  src_row;
    logic [7:0]  pix_red;
    logic [7:0]  pix_green;
    logic [7:0]  pix_blue;
    logic [7:0]  pix_alpha;
    logic [11:0] canvas_col;
    logic [11:0] canvas_row;
  } req_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // straight to premultiplied, rounded
  function automatic logic [7:0] premul(input logic [7:0] v, input logic [7:0] a);
    logic [15:0] s;
    logic [16:0] t;
    s = 16'(16'(v) * 16'(a)) + 16'd127;
    t = 17'(s) + 17'(s >> 8);
    return t[15:8];
  endfunction

  // clamp a coordinate to the last source index
  function automatic logic [6:0] clamp7(input logic [7:0] v, input logic [6:0] lim);
    return (v > {1'b0, lim}) ? lim : v[6:0];
  endfunction

endpackage

FILE: rtl/core/lbs_div.sv
module lbs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbs_pkg::div_req_t req_i,
  output lbs_pkg::div_rsp_t rsp_o
);
  import lbs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] dvs_q;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[DIV_NW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], fits};
      rem_q <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: rtl/core/letterbox_box_bilinear_scaler.sv
// letterbox scaler with box-average shrink and bilinear growth
//
// request channel: a request is taken on a rising edge with start high and
// busy low. a load request (func 0) writes one rgba pixel into the frame
// store in that same edge, gives no result and leaves busy low.
// a render request (func 1) asks for one canvas pixel; busy rises and the
// result comes out on rsp_o with valid_o high for exactly one cycle.
// there is no back-pressure: the receiver must take the result that cycle.
// a render ends in one of four ways: an error status, a black bar, a
// bilinear pixel, or a box average over the covered source pixels (up to
// 4096 pixels). each pass through the shared restoring divider gives 24
// quotient bits, and the single store read port (one pixel a cycle) sets
// the walk; these two set the render time.
// config writes (cfg_we_i) are registered; write only while idle.
// reset clears the config registers and the sequencer; the frame store is
// not cleared, so every pixel a render reads must have been loaded first.
module letterbox_box_bilinear_scaler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lbs_pkg::req_t req_i,
  output logic          valid_o,
  output lbs_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [12:0]   cfg_data_i
);
  import lbs_pkg::*;

  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW     = AW + 8;
  localparam int SW_CAP = (MAX_SRC_WIDTH > 127) ? 127 : MAX_SRC_WIDTH;
  localparam int SH_CAP = (MAX_SRC_HEIGHT > 127) ? 127 : MAX_SRC_HEIGHT;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_FIT, ST_FITW, ST_PLACE, ST_BAR, ST_XSW, ST_YSW,
    ST_LEFT, ST_TOP, ST_RNG, ST_BASE, ST_WALK, ST_DRAIN, ST_DIVB, ST_DIVG,
    ST_DIVR, ST_EMIT
  } state_e;

  // config registers
  logic [6:0]  src_w_q, src_h_q;
  logic [12:0] cnv_w_q, cnv_h_q;
  logic        straight_q;

  // sequencer registers
  state_e      state_q;
  logic [11:0] cx_q, cy_q;
  logic [19:0] prod_a_q, prod_b_q;
  logic        wide_q;
  logic [12:0] pw_q, ph_q;
  logic [11:0] px_q, py_q;
  logic [22:0] xs_q, ys_q, left_q, top_q;
  logic [6:0]  xa_q, xb_q, ya_q, yb_q, x_q, y_q;
  logic [7:0]  fx_q, fy_q;
  logic        avg_q;
  logic [AW-1:0] base0_q, base1_q;
  logic [1:0]  corner_q;
  logic [13:0] n_q;
  rsp_t        rsp_q;
  logic        valid_q;
  div_req_t    div_req_q;
  div_rsp_t    div_rsp;

  // store and pixel pipe
  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_data_q;
  logic        s1_v_q, s2_v_q;
  logic [1:0]  s1_c_q;
  logic [7:0]  pm_r_q, pm_g_q, pm_b_q;
  logic [16:0] w_q;
  logic [24:0] acc_r_q, acc_g_q, acc_b_q;

  // effective source size, saturated to the store
  logic [6:0]  sw_eff, sh_eff, lastc, lastr;
  assign sw_eff = (src_w_q > 7'(SW_CAP)) ? 7'(SW_CAP) : src_w_q;
  assign sh_eff = (src_h_q > 7'(SH_CAP)) ? 7'(SH_CAP) : src_h_q;
  assign lastc  = sw_eff - 7'd1;
  assign lastr  = sh_eff - 7'd1;

  // load write port
  logic          take, ld_we;
  logic [EW-1:0] ld_ext;
  assign take   = start && !busy;
  assign ld_we  = take && (req_i.func == FUNC_LOAD)
                  && (32'(req_i.src_col) < MAX_SRC_WIDTH)
                  && (32'(req_i.src_row) < MAX_SRC_HEIGHT);
  assign ld_ext = EW'(req_i.src_row) * EW'(MAX_SRC_WIDTH) + EW'(req_i.src_col);

  // covered source range and bilinear taps
  logic [23:0] sum_l, sum_t, sx, sy;
  logic [6:0]  fc, lc, fr, lr, x0, x1, y0, y1;
  always_comb begin
    sum_l = 24'(left_q) + 24'(xs_q) - 24'd1;
    sum_t = 24'(top_q) + 24'(ys_q) - 24'd1;
    sx    = 24'(left_q) + 24'(xs_q >> 1);
    sy    = 24'(top_q) + 24'(ys_q >> 1);
    fc    = clamp7({1'b0, left_q[22:16]}, lastc);
    lc    = clamp7(sum_l[23:16], lastc);
    fr    = clamp7({1'b0, top_q[22:16]}, lastr);
    lr    = clamp7(sum_t[23:16], lastr);
    x0    = clamp7(sx[23:16], lastc);
    y0    = clamp7(sy[23:16], lastr);
    x1    = (x0 == lastc) ? lastc : x0 + 7'd1;
    y1    = (y0 == lastr) ? lastr : y0 + 7'd1;
  end

  // black bar test
  logic in_place;
  assign in_place = (cx_q >= px_q) && (13'(cx_q) < 13'(px_q) + pw_q)
                    && (cy_q >= py_q) && (13'(cy_q) < 13'(py_q) + ph_q);

  // store read address
  logic          rd_en, walk_last;
  logic [AW-1:0] rd_base;
  logic [6:0]    rd_x;
  logic [EW-1:0] rd_ext;
  assign rd_en     = (state_q == ST_WALK);
  assign rd_base   = (!avg_q && corner_q[1]) ? base1_q : base0_q;
  assign rd_x      = avg_q ? x_q : (corner_q[0] ? xb_q : xa_q);
  assign rd_ext    = EW'(rd_base) + EW'(rd_x);
  assign walk_last = avg_q ? ((x_q == xb_q) && (y_q == yb_q)) : (corner_q == 2'd3);

  logic [EW-1:0] base_a, base_b, base_n;
  assign base_a = EW'(ya_q) * EW'(MAX_SRC_WIDTH);
  assign base_b = EW'(yb_q) * EW'(MAX_SRC_WIDTH);
  assign base_n = EW'(base0_q) + EW'(MAX_SRC_WIDTH);

  logic [34:0] left_p, top_p;
  assign left_p = 35'(cx_q - px_q) * 35'(xs_q);
  assign top_p  = 35'(cy_q - py_q) * 35'(ys_q);

  // bilinear rounding
  logic [24:0] rnd_r, rnd_g, rnd_b;
  assign rnd_r = acc_r_q + 25'd32768;
  assign rnd_g = acc_g_q + 25'd32768;
  assign rnd_b = acc_b_q + 25'd32768;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= '0;
      src_h_q    <= '0;
      cnv_w_q    <= '0;
      cnv_h_q    <= '0;
      straight_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:      src_w_q    <= cfg_data_i[6:0];
        REG_SRC_HEIGHT:     src_h_q    <= cfg_data_i[6:0];
        REG_CANVAS_WIDTH:   cnv_w_q    <= cfg_data_i;
        REG_CANVAS_HEIGHT:  cnv_h_q    <= cfg_data_i;
        REG_STRAIGHT_ALPHA: straight_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= 1'b0;
      div_req_q.go <= 1'b0;
    end else begin
      valid_q      <= 1'b0;
      div_req_q.go <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (take && req_i.func == FUNC_RENDER) begin
            cx_q    <= req_i.canvas_col;
            cy_q    <= req_i.canvas_row;
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          rsp_q.out_blue  <= '0;
          rsp_q.out_green <= '0;
          rsp_q.out_red   <= '0;
          if (sw_eff == '0 || sh_eff == '0 || cnv_w_q == '0 || cnv_h_q == '0) begin
            rsp_q.status <= STAT_ZERO_DIM;
            valid_q      <= 1'b1;
            state_q      <= ST_EMIT;
          end else if (13'(cx_q) >= cnv_w_q || 13'(cy_q) >= cnv_h_q) begin
            rsp_q.status <= STAT_OUTSIDE;
            valid_q      <= 1'b1;
            state_q      <= ST_EMIT;
          end else begin
            rsp_q.status <= STAT_OK;
            prod_a_q     <= 20'(sw_eff) * 20'(cnv_h_q);
            prod_b_q     <= 20'(cnv_w_q) * 20'(sh_eff);
            state_q      <= ST_FIT;
          end
        end
        ST_FIT: begin
          // full width when the source is relatively wider, or on a tie
          wide_q             <= prod_a_q >= prod_b_q;
          div_req_q.go       <= 1'b1;
          div_req_q.dividend <= (prod_a_q >= prod_b_q) ? 24'(prod_b_q) : 24'(prod_a_q);
          div_req_q.divisor  <= (prod_a_q >= prod_b_q) ? 14'(sw_eff) : 14'(sh_eff);
          state_q            <= ST_FITW;
        end
        ST_FITW: begin
          if (div_rsp.done) begin
            if (wide_q) begin
              pw_q <= cnv_w_q;
              ph_q <= (div_rsp.quot == '0) ? 13'd1 : div_rsp.quot[12:0];
            end else begin
              ph_q <= cnv_h_q;
              pw_q <= (div_rsp.quot == '0) ? 13'd1 : div_rsp.quot[12:0];
            end
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          px_q    <= 12'((cnv_w_q - pw_q) >> 1);
          py_q    <= 12'((cnv_h_q - ph_q) >> 1);
          state_q <= ST_BAR;
        end
        ST_BAR: begin
          if (!in_place) begin
            valid_q <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= 24'({sw_eff, 16'h0000});
            div_req_q.divisor  <= 14'(pw_q);
            state_q            <= ST_XSW;
          end
        end
        ST_XSW: begin
          if (div_rsp.done) begin
            xs_q               <= div_rsp.quot[22:0];
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= 24'({sh_eff, 16'h0000});
            div_req_q.divisor  <= 14'(ph_q);
            state_q            <= ST_YSW;
          end
        end
        ST_YSW: begin
          if (div_rsp.done) begin
            ys_q    <= div_rsp.quot[22:0];
            state_q <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          left_q  <= left_p[22:0];
          state_q <= ST_TOP;
        end
        ST_TOP: begin
          top_q   <= top_p[22:0];
          state_q <= ST_RNG;
        end
        ST_RNG: begin
          avg_q <= (lc > fc) || (lr > fr);
          fx_q  <= sx[15:8];
          fy_q  <= sy[15:8];
          if ((lc > fc) || (lr > fr)) begin
            xa_q <= fc;
            xb_q <= lc;
            ya_q <= fr;
            yb_q <= lr;
          end else begin
            xa_q <= x0;
            xb_q <= x1;
            ya_q <= y0;
            yb_q <= y1;
          end
          state_q <= ST_BASE;
        end
        ST_BASE: begin
          base0_q  <= base_a[AW-1:0];
          base1_q  <= base_b[AW-1:0];
          x_q      <= xa_q;
          y_q      <= ya_q;
          corner_q <= 2'd0;
          n_q      <= '0;
          state_q  <= ST_WALK;
        end
        ST_WALK: begin
          // one store read per cycle
          corner_q <= corner_q + 2'd1;
          n_q      <= n_q + 14'd1;
          // row walk only for the box average, the taps keep both row bases
          if (avg_q) begin
            if (x_q == xb_q) begin
              x_q <= xa_q;
              if (y_q != yb_q) begin
                y_q     <= y_q + 7'd1;
                base0_q <= base_n[AW-1:0];
              end
            end else begin
              x_q <= x_q + 7'd1;
            end
          end
          if (walk_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_v_q && !s2_v_q) begin
            if (avg_q) begin
              div_req_q.go       <= 1'b1;
              div_req_q.dividend <= acc_b_q[23:0];
              div_req_q.divisor  <= n_q;
              state_q            <= ST_DIVB;
            end else begin
              rsp_q.out_blue  <= rnd_b[23:16];
              rsp_q.out_green <= rnd_g[23:16];
              rsp_q.out_red   <= rnd_r[23:16];
              valid_q         <= 1'b1;
              state_q         <= ST_EMIT;
            end
          end
        end
        ST_DIVB: begin
          if (div_rsp.done) begin
            rsp_q.out_blue     <= div_rsp.quot[7:0];
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= acc_g_q[23:0];
            state_q            <= ST_DIVG;
          end
        end
        ST_DIVG: begin
          if (div_rsp.done) begin
            rsp_q.out_green    <= div_rsp.quot[7:0];
            div_req_q.go       <= 1'b1;
            div_req_q.dividend <= acc_r_q[23:0];
            state_q            <= ST_DIVR;
          end
        end
        ST_DIVR: begin
          if (div_rsp.done) begin
            rsp_q.out_red <= div_rsp.quot[7:0];
            valid_q       <= 1'b1;
            state_q       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem_q[ld_ext[AW-1:0]] <= {req_i.pix_alpha, req_i.pix_blue,
                                req_i.pix_green, req_i.pix_red};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_ext[AW-1:0]];
    end
  end

  // pixel pipe: read, premultiply and weigh, accumulate
  logic [8:0]  wx, wy;
  logic [17:0] wprod;
  assign wx    = s1_c_q[0] ? {1'b0, fx_q} : 9'd256 - {1'b0, fx_q};
  assign wy    = s1_c_q[1] ? {1'b0, fy_q} : 9'd256 - {1'b0, fy_q};
  assign wprod = 18'(wx) * 18'(wy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= rd_en;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_c_q <= corner_q;
    end
    if (s1_v_q) begin
      pm_r_q <= straight_q ? premul(rd_data_q[7:0], rd_data_q[31:24]) : rd_data_q[7:0];
      pm_g_q <= straight_q ? premul(rd_data_q[15:8], rd_data_q[31:24]) : rd_data_q[15:8];
      pm_b_q <= straight_q ? premul(rd_data_q[23:16], rd_data_q[31:24]) : rd_data_q[23:16];
      w_q    <= avg_q ? 17'd1 : wprod[16:0];
    end
    if (state_q == ST_BASE) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (s2_v_q) begin
      acc_r_q <= acc_r_q + 25'(pm_r_q) * 25'(w_q);
      acc_g_q <= acc_g_q + 25'(pm_g_q) * 25'(w_q);
      acc_b_q <= acc_b_q + 25'(pm_b_q) * 25'(w_q);
    end
  end

  lbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: rtl/core/lbs_chk.sv
module lbs_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input lbs_pkg::req_t req_i,
  input logic          valid_o,
  input lbs_pkg::rsp_t rsp_o
);
  import lbs_pkg::*;

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside a render");

  a_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.status != STAT_OK |->
      rsp_o.out_blue == '0 && rsp_o.out_green == '0 && rsp_o.out_red == '0)
    else $error("error status with nonzero color");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.func == FUNC_LOAD |=> !busy && !valid_o)
    else $error("load request started work");

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.func == FUNC_RENDER |=> busy && !valid_o)
    else $error("render request not taken");

endmodule

bind letterbox_box_bilinear_scaler lbs_chk u_lbs_chk (.*);
